@@ src/dtis_pkg.sv @@
// ----------------------------------------------------------------------------
// dtis_pkg
// Shared types and constants for the decimal text to integer converter:
// configuration register indexes and the result word layout.
// ----------------------------------------------------------------------------
package dtis_pkg;

    localparam int CHAR_W    = 8;
    localparam int VALUE_W   = 64;
    localparam int CFG_IDX_W = 1;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_SIGNED_MODE = 1'b0;
    localparam cfg_index_t CFG_WIDE_MODE   = 1'b1;

    typedef struct packed {
        logic [VALUE_W-1:0] value_bits;
        logic               saturated;
        logic               no_digits;
    } dtis_result_t;

endpackage

@@ src/decimal_text_to_integer_saturating.sv @@
// A word that ends a field passes from the input register through the field
// parser into the output register. Throughput: one character word per cycle,
// except while a field-ending word waits on a stalled output.
// A result waiting on the output holds back only a character that ends a field.
// Reset clears the field state and both stages; signed_mode and wide_mode reset to 1.
// ----------------------------------------------------------------------------
// decimal_text_to_integer_saturating
// Streaming decimal text to integer converter with saturation, taking one
// character per word and giving one result word per field.
// ----------------------------------------------------------------------------
module decimal_text_to_integer_saturating (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  dtis_pkg::cfg_index_t          cfg_index,
    input  logic                          cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [dtis_pkg::CHAR_W-1:0]   char_code,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [dtis_pkg::VALUE_W-1:0]  value_bits,
    output logic                          saturated,
    output logic                          no_digits
);

    logic                        signed_mode_reg;
    logic                        wide_mode_reg;
    logic                        in_valid_reg;
    logic [dtis_pkg::CHAR_W-1:0] char_reg;
    logic                        out_valid_reg;
    dtis_pkg::dtis_result_t      result_reg;
    dtis_pkg::dtis_result_t      result_next;

    logic ends_field;
    logic out_free;
    logic advance;

    dtis_field u_field (
        .clk         (clk),
        .rst_n       (rst_n),
        .signed_mode (signed_mode_reg),
        .wide_mode   (wide_mode_reg),
        .char_code   (char_reg),
        .step        (advance),
        .ends_field  (ends_field),
        .result      (result_next)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && (!ends_field || out_free);
    assign in_ready = !in_valid_reg || advance;

    assign out_valid  = out_valid_reg;
    assign value_bits = result_reg.value_bits;
    assign saturated  = result_reg.saturated;
    assign no_digits  = result_reg.no_digits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signed_mode_reg <= 1'b1;
            wide_mode_reg   <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                dtis_pkg::CFG_SIGNED_MODE: signed_mode_reg <= cfg_data;
                dtis_pkg::CFG_WIDE_MODE:   wide_mode_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= advance && ends_field;
            end
        end
    end

    // hold payload until the next word or result loads
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_reg <= char_code;
        end
        if (advance && ends_field && out_free)
        begin
            result_reg <= result_next;
        end
    end

endmodule

@@ src/dtis_field.sv @@
// ----------------------------------------------------------------------------
// dtis_field
// Field parser: holds the state of the field in progress, accumulates
// digits with overflow detection and forms the clamped result word.
// ----------------------------------------------------------------------------
module dtis_field (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        signed_mode,
    input  logic                        wide_mode,
    input  logic [dtis_pkg::CHAR_W-1:0] char_code,
    input  logic                        step,
    output logic                        ends_field,
    output dtis_pkg::dtis_result_t      result
);

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [63:0] LIM_U64     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LIM_S64_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LIM_S64_NEG = 64'h8000_0000_0000_0000;
    localparam logic [63:0] LIM_U32     = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] LIM_S32_POS = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] LIM_S32_NEG = 64'h0000_0000_8000_0000;

    localparam logic [63:0] QUOT_U64 = 64'd1844674407370955161;
    localparam logic [63:0] QUOT_S64 = 64'd922337203685477580;
    localparam logic [63:0] QUOT_U32 = 64'd429496729;
    localparam logic [63:0] QUOT_S32 = 64'd214748364;

    logic        in_field_reg,  in_field_next;
    logic [63:0] magnitude_reg, magnitude_next;
    logic        negative_reg,  negative_next;
    logic        overflow_reg,  overflow_next;
    logic        seen_digit_reg, seen_digit_next;

    logic        is_digit;
    logic        is_space;
    logic        is_sign;
    logic [3:0]  digit;
    logic        neg;
    logic [63:0] lim;
    logic [63:0] quot;
    logic [3:0]  rem;
    logic        digit_over;
    logic [63:0] mag_scaled;
    logic        sat;
    logic [63:0] clamped;
    logic [63:0] value;

    always_comb
    begin
        is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
        is_space = (char_code == CHAR_SPACE);
        is_sign  = signed_mode && ((char_code == CHAR_PLUS) || (char_code == CHAR_MINUS));
        digit    = char_code[3:0];
        ends_field = !is_digit && !(!in_field_reg && (is_space || is_sign));
        neg      = signed_mode && negative_reg;

        case ({wide_mode, signed_mode, neg})
            3'b100, 3'b101:
            begin
                lim = LIM_U64;     quot = QUOT_U64; rem = 4'd5;
            end
            3'b110:
            begin
                lim = LIM_S64_POS; quot = QUOT_S64; rem = 4'd7;
            end
            3'b111:
            begin
                lim = LIM_S64_NEG; quot = QUOT_S64; rem = 4'd8;
            end
            3'b000, 3'b001:
            begin
                lim = LIM_U32;     quot = QUOT_U32; rem = 4'd5;
            end
            3'b010:
            begin
                lim = LIM_S32_POS; quot = QUOT_S32; rem = 4'd7;
            end
            default:
            begin
                lim = LIM_S32_NEG; quot = QUOT_S32; rem = 4'd8;
            end
        endcase

        digit_over = (magnitude_reg > quot) || ((magnitude_reg == quot) && (digit > rem));
        mag_scaled = (magnitude_reg << 3) + (magnitude_reg << 1) + {60'd0, digit};

        sat     = overflow_reg || (magnitude_reg > lim);
        clamped = sat ? lim : magnitude_reg;
        value   = neg ? (64'd0 - clamped) : clamped;
        if (!wide_mode)
        begin
            value[63:32] = 32'd0;
        end
        result.value_bits = value;
        result.saturated  = sat;
        result.no_digits  = !seen_digit_reg;
    end

    always_comb
    begin
        in_field_next   = in_field_reg;
        magnitude_next  = magnitude_reg;
        negative_next   = negative_reg;
        overflow_next   = overflow_reg;
        seen_digit_next = seen_digit_reg;
        if (step)
        begin
            if (is_digit)
            begin
                seen_digit_next = 1'b1;
                in_field_next   = 1'b1;
                if (!overflow_reg)
                begin
                    if (digit_over)
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        magnitude_next = mag_scaled;
                    end
                end
            end
            else if (ends_field)
            begin
                in_field_next   = 1'b0;
                magnitude_next  = 64'd0;
                negative_next   = 1'b0;
                overflow_next   = 1'b0;
                seen_digit_next = 1'b0;
            end
            else if (is_sign)
            begin
                negative_next = (char_code == CHAR_MINUS);
                in_field_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_field_reg   <= 1'b0;
            magnitude_reg  <= 64'd0;
            negative_reg   <= 1'b0;
            overflow_reg   <= 1'b0;
            seen_digit_reg <= 1'b0;
        end
        else
        begin
            in_field_reg   <= in_field_next;
            magnitude_reg  <= magnitude_next;
            negative_reg   <= negative_next;
            overflow_reg   <= overflow_next;
            seen_digit_reg <= seen_digit_next;
        end
    end

endmodule

@@ src/dtis_checker.sv @@
// ----------------------------------------------------------------------------
// dtis_checker
// Port-level checks for the decimal text to integer converter, bound to the
// top level.
// ----------------------------------------------------------------------------
module dtis_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [dtis_pkg::VALUE_W-1:0]  value_bits,
    input logic                          saturated,
    input logic                          no_digits
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(value_bits) && $stable(saturated)
            && $stable(no_digits))
        else $error("result word changed while stalled");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_digits |-> (value_bits == '0) && !saturated)
        else $error("field without digits gave a nonzero or clamped value");

    a_sat_digits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> !no_digits)
        else $error("clamped result from a field without digits");

endmodule

bind decimal_text_to_integer_saturating dtis_checker u_dtis_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value_bits (value_bits),
    .saturated  (saturated),
    .no_digits  (no_digits)
);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal text to integer converter testbench
// Streams character words through the converter in every signed and width
// mode, predicts each field's value, clamp flag and empty-field flag, and
// compares every result word in order against the prediction.
// ----------------------------------------------------------------------------
package text_check_pkg;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    class integer_field_checker;

        bit                     signed_mode;
        bit                     wide_mode;
        bit                     in_digits;
        logic [63:0]            magnitude;
        bit                     minus_seen;
        bit                     clamped;
        bit                     digit_seen;
        dtis_pkg::dtis_result_t pending_values[$];
        int                     mismatches;

        function new();
            signed_mode = 1'b1;
            wide_mode   = 1'b1;
            mismatches  = 0;
            clear_field();
        endfunction

        function void clear_field();
            in_digits  = 1'b0;
            magnitude  = '0;
            minus_seen = 1'b0;
            clamped    = 1'b0;
            digit_seen = 1'b0;
        endfunction

        function logic [63:0] range_limit(bit neg);
            if (wide_mode)
            begin
                if (!signed_mode)
                    return 64'hFFFF_FFFF_FFFF_FFFF;
                return neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            end
            if (!signed_mode)
                return 64'h0000_0000_FFFF_FFFF;
            return neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
        endfunction

        function void accumulate(logic [63:0] digit);
            logic [63:0] lim;
            lim = range_limit(signed_mode && minus_seen);
            digit_seen = 1'b1;
            if (clamped)
                return;
            if (magnitude > lim / 64'd10 ||
                (magnitude == lim / 64'd10 && digit > lim % 64'd10))
            begin
                clamped = 1'b1;
                return;
            end
            magnitude = magnitude * 64'd10 + digit;
        endfunction

        function void take_char(logic [7:0] c);
            logic [63:0]            lim;
            logic [63:0]            m;
            logic [63:0]            v;
            bit                     neg;
            bit                     sat;
            dtis_pkg::dtis_result_t r;
            if (c >= CH_ZERO && c <= CH_NINE)
            begin
                accumulate(64'(c - CH_ZERO));
                in_digits = 1'b1;
                return;
            end
            if (!in_digits)
            begin
                if (c == CH_SPACE)
                    return;
                if (signed_mode && (c == CH_PLUS || c == CH_MINUS))
                begin
                    minus_seen = (c == CH_MINUS);
                    in_digits  = 1'b1;
                    return;
                end
            end
            neg = signed_mode && minus_seen;
            lim = range_limit(neg);
            sat = clamped || magnitude > lim;
            m   = sat ? lim : magnitude;
            v   = neg ? (64'd0 - m) : m;
            if (!wide_mode)
                v[63:32] = '0;
            r.value_bits = v;
            r.saturated  = sat;
            r.no_digits  = !digit_seen;
            pending_values.push_back(r);
            clear_field();
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch: %s got %h want %h", what, got, want);
            mismatches++;
        endtask

        task check_word(dtis_pkg::dtis_result_t got);
            dtis_pkg::dtis_result_t want;
            if (pending_values.size() == 0)
            begin
                report_mismatch("result word with no field pending", got.value_bits, '0);
                return;
            end
            want = pending_values.pop_front();
            if (got.value_bits !== want.value_bits)
                report_mismatch("value_bits", got.value_bits, want.value_bits);
            if (got.saturated !== want.saturated)
                report_mismatch("saturated", 64'(got.saturated), 64'(want.saturated));
            if (got.no_digits !== want.no_digits)
                report_mismatch("no_digits", 64'(got.no_digits), 64'(want.no_digits));
        endtask

    endclass

endpackage

module testbench;

    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_CHARS   = 350;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_write;
    dtis_pkg::cfg_index_t          cfg_index;
    logic                          cfg_data;
    logic                          in_valid;
    logic                          in_ready;
    logic [dtis_pkg::CHAR_W-1:0]   char_code;
    logic                          out_valid;
    logic                          out_ready;
    logic [dtis_pkg::VALUE_W-1:0]  value_bits;
    logic                          saturated;
    logic                          no_digits;

    text_check_pkg::integer_field_checker checker_h = new();
    int                     chars_sent;
    int                     stall_cycles;
    bit                     calm;
    bit                     hold_request;
    dtis_pkg::dtis_result_t got_word;
    string                  limit_text[6] = '{"4294967295", "2147483647", "2147483648",
                                              "9223372036854775807", "9223372036854775808",
                                              "18446744073709551615"};

    decimal_text_to_integer_saturating u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .char_code  (char_code),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .value_bits (value_bits),
        .saturated  (saturated),
        .no_digits  (no_digits)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // hold off the result side on request, otherwise stall at random unless calm
    always
    begin
        @(negedge clk);
        if (hold_request)
        begin
            out_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clk);
            hold_request = 1'b0;
        end
        else
        begin
            out_ready <= calm || ($urandom_range(0, 99) >= 26);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                checker_h.take_char(char_code);
            if (out_valid && out_ready)
            begin
                got_word.value_bits = value_bits;
                got_word.saturated  = saturated;
                got_word.no_digits  = no_digits;
                checker_h.check_word(got_word);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("testbench: done, errors");
        $finish;
    end

    task automatic send_char(logic [7:0] c);
        while (!calm && $urandom_range(0, 99) < 26)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        char_code <= c;
        do
            @(posedge clk);
        while (!in_ready);
        chars_sent++;
    endtask

    task automatic send_text(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    function automatic logic [7:0] pick_terminator();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: c = text_check_pkg::CH_SPACE;
            5, 6:          c = text_check_pkg::CH_COMMA;
            default:
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (c >= text_check_pkg::CH_ZERO && c <= text_check_pkg::CH_NINE);
            end
        endcase
        return c;
    endfunction

    task automatic send_field(bit closed);
        string s;
        int    kind;
        case ($urandom_range(0, 5))
            0: send_char(text_check_pkg::CH_SPACE);
            1: repeat ($urandom_range(2, 4)) send_char(text_check_pkg::CH_SPACE);
            default: ;
        endcase
        case ($urandom_range(0, 3))
            0: send_char(text_check_pkg::CH_PLUS);
            1: send_char(text_check_pkg::CH_MINUS);
            default: ;
        endcase
        kind = $urandom_range(0, 9);
        if (kind < 4)
        begin
            repeat ($urandom_range(1, kind == 0 ? 24 : 6))
                send_char(8'(text_check_pkg::CH_ZERO + $urandom_range(0, 9)));
        end
        else if (kind < 9)
        begin
            s = limit_text[$urandom_range(0, 5)];
            s[s.len() - 1] = 8'(text_check_pkg::CH_ZERO + $urandom_range(0, 9));
            if ($urandom_range(0, 4) == 0)
                s = {"00", s};
            send_text(s);
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 3))
                    send_char(8'(text_check_pkg::CH_ZERO + $urandom_range(0, 9)));
        end
        if (closed)
            send_char(pick_terminator());
    endtask

    task automatic run_random(int count);
        int stop;
        stop = chars_sent + count;
        while (chars_sent < stop)
        begin
            if ($urandom_range(0, 99) < 15)
                repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)));
            else
                send_field(1'b1);
        end
        // leave a field open across the next mode change
        send_field(1'b0);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (checker_h.pending_values.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(dtis_pkg::cfg_index_t idx, logic d);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_modes(bit signed_sel, bit wide_sel);
        drain();
        write_register(dtis_pkg::CFG_SIGNED_MODE, signed_sel);
        write_register(dtis_pkg::CFG_WIDE_MODE, wide_sel);
        checker_h.signed_mode = signed_sel;
        checker_h.wide_mode   = wide_sel;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = dtis_pkg::CFG_SIGNED_MODE;
        cfg_data     = 1'b0;
        in_valid     = 1'b0;
        char_code    = '0;
        out_ready    = 1'b0;
        chars_sent   = 0;
        calm         = 1'b0;
        hold_request = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // signed 64-bit after reset: empty fields, signs, odd terminators
        send_char(8'h00);
        send_text("  +7");
        send_char(8'hFF);
        send_text("-0 +-- -5x");
        run_random(PHASE_CHARS);

        set_modes(1'b0, 1'b0);
        send_text("-12+3 ");
        run_random(PHASE_CHARS / 2);
        hold_request = 1'b1;
        run_random(PHASE_CHARS / 2);

        set_modes(1'b1, 1'b0);
        calm = 1'b1;
        run_random(PHASE_CHARS);
        calm = 1'b0;

        set_modes(1'b0, 1'b1);
        run_random(PHASE_CHARS);

        set_modes(1'b1, 1'b1);
        run_random(PHASE_CHARS);
        send_char(text_check_pkg::CH_SPACE);
        drain();
        repeat (10) @(posedge clk);

        if (checker_h.mismatches == 0 && checker_h.pending_values.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
